### sv/pf_pkg.sv
package pf_pkg;

  localparam int CODE_W   = 5;
  localparam int REG_ROWS = 5;
  localparam int REG_COLS = 5;
  localparam int ROW_W    = REG_COLS * CODE_W;
  localparam int CFG_IDX_W = 3;
  // row/column index width; covers square sides up to 8
  localparam int IDX_W    = 3;
  localparam int SIDE_DEFAULT = 5;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_SAME = 2'd2
  } status_e;

  typedef logic [REG_ROWS-1:0][REG_COLS-1:0][CODE_W-1:0] square_t;

  typedef struct packed {
    op_e               opcode;
    logic [CODE_W-1:0] first_letter;
    logic [CODE_W-1:0] second_letter;
  } pair_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] out_first;
    logic [CODE_W-1:0] out_second;
    status_e           status;
  } pair_out_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } loc_t;

  // cells outside the register bits read as code 0
  function automatic logic [CODE_W-1:0] cell_read(input square_t sq,
                                                  input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    logic [CODE_W-1:0] v;
    v = '0;
    if ((int'(r) < REG_ROWS) && (int'(c) < REG_COLS)) begin
      v = sq[r][c];
    end
    return v;
  endfunction

endpackage

### sv/playfair_digraph_cipher.sv
// Playfair digraph cipher over a configurable key square.
//
// Configuration: write cfg_wdata_i into row cfg_idx_i (0 top .. 4 bottom) of
// the key square while cfg_we_i is high; column 0 sits in the low five bits.
// Indexes past the last row are ignored. Write only while no pair is in flight.
//
// Input: a pair (opcode, first_letter, second_letter) is taken on every clock
// edge with start_i high; busy_o stays low, so a new pair may follow in every
// cycle. Two lookup lanes locate the letters in parallel, a merge stage
// applies the same-column, same-row or rectangle rule, or flags a missing letter or a shared cell.
//
// Output: done_o pulses for one cycle with the result on res_o, which passes
// the lane register, then the merge register. Throughput is one pair per
// cycle. The receiver cannot stall; done_o marks each result for one cycle
// only, and res_o holds it until the next result.
//
// Reset: rst_ni clears the key square to all zero codes and empties the
// pipeline; no result is pending after reset.
module playfair_digraph_cipher #(
  parameter int SQUARE_SIDE = pf_pkg::SIDE_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pf_pkg::ROW_W-1:0]     cfg_wdata_i,
  input  logic                         start_i,
  input  pf_pkg::pair_in_t             in_i,
  output logic                         busy_o,
  output logic                         done_o,
  output pf_pkg::pair_out_t            res_o
);
  import pf_pkg::*;

  square_t  square_q;
  logic     s1_valid_q;
  pair_in_t s1_q;
  loc_t     loc_a, loc_b;
  logic     accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_q <= '0;
    end else if (cfg_we_i && (int'(cfg_idx_i) < REG_ROWS)) begin
      square_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_i;
    end
  end

  pf_lane #(.SQUARE_SIDE(SQUARE_SIDE)) u_lane_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .square_i(square_q),
    .letter_i(in_i.first_letter),
    .loc_o   (loc_a)
  );

  pf_lane #(.SQUARE_SIDE(SQUARE_SIDE)) u_lane_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .square_i(square_q),
    .letter_i(in_i.second_letter),
    .loc_o   (loc_b)
  );

  pf_merge #(.SQUARE_SIDE(SQUARE_SIDE)) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .pair_i  (s1_q),
    .loc_a_i (loc_a),
    .loc_b_i (loc_b),
    .square_i(square_q),
    .done_o  (done_o),
    .res_o   (res_o)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("result strobe missing two cycles after start");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s1_valid_q))
    else $error("result strobe without a transaction in flight");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.status == ST_OK || res_o.status == ST_MISS ||
                res_o.status == ST_SAME))
    else $error("illegal status code");

  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status != ST_OK) |->
      (res_o.out_first == $past(s1_q.first_letter)) &&
      (res_o.out_second == $past(s1_q.second_letter)))
    else $error("pair not passed through on error status");
`endif

endmodule

### sv/pf_lane.sv
module pf_lane #(
  parameter int SQUARE_SIDE = pf_pkg::SIDE_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  pf_pkg::square_t           square_i,
  input  logic [pf_pkg::CODE_W-1:0] letter_i,
  output pf_pkg::loc_t              loc_o
);
  import pf_pkg::*;

  logic [SQUARE_SIDE-1:0][SQUARE_SIDE-1:0] hit;
  logic [SQUARE_SIDE-1:0]                  row_any;
  loc_t loc_d, loc_q;

  for (genvar r = 0; r < SQUARE_SIDE; r++) begin : g_row
    for (genvar c = 0; c < SQUARE_SIDE; c++) begin : g_col
      if ((r < REG_ROWS) && (c < REG_COLS)) begin : g_cell
        assign hit[r][c] = (square_i[r][c] == letter_i);
      end else begin : g_none
        assign hit[r][c] = 1'b0;
      end
    end
    assign row_any[r] = |hit[r];
  end

  // first match in row-major order: lowest row, then lowest column in it
  always_comb begin
    loc_d = '0;
    loc_d.found = |row_any;
    for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
      if (row_any[r]) loc_d.row = IDX_W'(r);
    end
    for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
      if (hit[loc_d.row][c]) loc_d.col = IDX_W'(c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q <= '0;
    end else if (en_i) begin
      loc_q <= loc_d;
    end
  end

  assign loc_o = loc_q;

endmodule

### sv/pf_merge.sv
module pf_merge #(
  parameter int SQUARE_SIDE = pf_pkg::SIDE_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pf_pkg::pair_in_t  pair_i,
  input  pf_pkg::loc_t      loc_a_i,
  input  pf_pkg::loc_t      loc_b_i,
  input  pf_pkg::square_t   square_i,
  output logic              done_o,
  output pf_pkg::pair_out_t res_o
);
  import pf_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SQUARE_SIDE - 1);

  function automatic logic [IDX_W-1:0] wrap_step(input logic [IDX_W-1:0] v,
                                                 input op_e op);
    logic [IDX_W-1:0] n;
    if (op == OP_DEC) begin
      n = (v == '0) ? LAST : v - IDX_W'(1);
    end else begin
      n = (v == LAST) ? '0 : v + IDX_W'(1);
    end
    return n;
  endfunction

  pair_out_t res_d, res_q;
  logic      done_q;

  always_comb begin
    res_d.out_first  = pair_i.first_letter;
    res_d.out_second = pair_i.second_letter;
    res_d.status     = ST_OK;
    if (!loc_a_i.found || !loc_b_i.found) begin
      res_d.status = ST_MISS;
    end else if ((loc_a_i.row == loc_b_i.row) && (loc_a_i.col == loc_b_i.col)) begin
      res_d.status = ST_SAME;
    end else if (loc_a_i.col == loc_b_i.col) begin
      res_d.out_first  = cell_read(square_i, wrap_step(loc_a_i.row, pair_i.opcode),
                                   loc_a_i.col);
      res_d.out_second = cell_read(square_i, wrap_step(loc_b_i.row, pair_i.opcode),
                                   loc_b_i.col);
    end else if (loc_a_i.row == loc_b_i.row) begin
      res_d.out_first  = cell_read(square_i, loc_a_i.row,
                                   wrap_step(loc_a_i.col, pair_i.opcode));
      res_d.out_second = cell_read(square_i, loc_b_i.row,
                                   wrap_step(loc_b_i.col, pair_i.opcode));
    end else begin
      // rectangle: swap columns
      res_d.out_first  = cell_read(square_i, loc_a_i.row, loc_b_i.col);
      res_d.out_second = cell_read(square_i, loc_b_i.row, loc_a_i.col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### bench/tb_playfair_digraph_cipher.sv
module tb_playfair_digraph_cipher;
  import pf_pkg::*;

  localparam int SIDE     = SIDE_DEFAULT;
  localparam int IDX_TOP  = (1 << CFG_IDX_W) - 1;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_PAIRS = 100;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [ROW_W-1:0]     cfg_wdata_i = '0;
  logic                 start_i     = 1'b0;
  pair_in_t             in_i        = '0;
  logic                 busy_o;
  logic                 done_o;
  pair_out_t            res_o;

  playfair_digraph_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  // key square as seen through the config port
  square_t   key_sq;
  pair_in_t  pair_backlog[$];
  pair_out_t cipher_out_q[$];
  pair_out_t want;
  int        n_issued  = 0;
  int        n_taken   = 0;
  int        n_errors  = 0;
  int        n_squares = 0;
  int        n_ok      = 0;
  int        n_miss    = 0;
  int        n_same    = 0;
  int        gap_left  = 0;
  bit        idle_en   = 1'b1;
  bit        pair_taken;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // first match in row-major order
  function automatic bit find_cell(input square_t sq, input logic [CODE_W-1:0] code,
                                   output int row, output int col);
    bit hit;
    hit = 1'b0;
    row = 0;
    col = 0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (!hit && r < REG_ROWS && c < REG_COLS && sq[r][c] == code) begin
          hit = 1'b1;
          row = r;
          col = c;
        end
      end
    end
    return hit;
  endfunction

  function automatic logic [CODE_W-1:0] code_at(input square_t sq, input int r, input int c);
    return (r < REG_ROWS && c < REG_COLS) ? sq[r][c] : '0;
  endfunction

  function automatic pair_out_t playfair_pair(input square_t sq, input pair_in_t p);
    pair_out_t o;
    int        r1, c1, r2, c2, step;
    bit        f1, f2;
    o.out_first  = p.first_letter;
    o.out_second = p.second_letter;
    o.status     = ST_OK;
    step = (p.opcode == OP_DEC) ? SIDE - 1 : 1;
    f1 = find_cell(sq, p.first_letter, r1, c1);
    f2 = find_cell(sq, p.second_letter, r2, c2);
    if (!f1 || !f2) begin
      o.status = ST_MISS;
    end else if (r1 == r2 && c1 == c2) begin
      o.status = ST_SAME;
    end else if (c1 == c2) begin
      o.out_first  = code_at(sq, (r1 + step) % SIDE, c1);
      o.out_second = code_at(sq, (r2 + step) % SIDE, c2);
    end else if (r1 == r2) begin
      o.out_first  = code_at(sq, r1, (c1 + step) % SIDE);
      o.out_second = code_at(sq, r2, (c2 + step) % SIDE);
    end else begin
      o.out_first  = code_at(sq, r1, c2);
      o.out_second = code_at(sq, r2, c1);
    end
    return o;
  endfunction

  // driver: holds the current pair until taken, random idle bursts between pairs
  always @(negedge clk_i) begin
    if (!start_i || pair_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (rst_ni && pair_backlog.size() != 0) begin
        if (idle_en && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 15);
          start_i  <= 1'b0;
        end else begin
          start_i <= 1'b1;
          in_i    <= pair_backlog.pop_front();
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: tracks config writes, predicts on each taken pair, checks results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_sq     = '0;
      pair_taken <= 1'b0;
    end else begin
      pair_taken <= start_i && !busy_o;
      if (cfg_we_i && cfg_idx_i < REG_ROWS) begin
        key_sq[cfg_idx_i] = cfg_wdata_i;
      end
      if (start_i && !busy_o) begin
        want = playfair_pair(key_sq, in_i);
        cipher_out_q.insert(cipher_out_q.size(), want);
        n_taken++;
        case (want.status)
          ST_OK:   n_ok++;
          ST_MISS: n_miss++;
          default: n_same++;
        endcase
      end
      if (done_o) begin
        if (cipher_out_q.size() == 0) begin
          $error("unexpected result transaction: out_first %0d out_second %0d status %0d",
                 res_o.out_first, res_o.out_second, res_o.status);
          n_errors++;
        end else begin
          want = cipher_out_q.pop_front();
          if (res_o.out_first !== want.out_first) begin
            $error("out_first: expected %0d, got %0d", want.out_first, res_o.out_first);
            n_errors++;
          end
          if (res_o.out_second !== want.out_second) begin
            $error("out_second: expected %0d, got %0d", want.out_second, res_o.out_second);
            n_errors++;
          end
          if (res_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_o.status);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic queue_pair(input op_e op, input int a, input int b);
    pair_in_t p;
    p.opcode        = op;
    p.first_letter  = a[CODE_W-1:0];
    p.second_letter = b[CODE_W-1:0];
    pair_backlog.insert(pair_backlog.size(), p);
    n_issued++;
  endtask

  task automatic wait_drained;
    do @(negedge clk_i);
    while (!(n_taken == n_issued && cipher_out_q.size() == 0));
  endtask

  task automatic write_reg(input int idx, input logic [ROW_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx[CFG_IDX_W-1:0];
    cfg_wdata_i <= val;
  endtask

  // all rows, plus one write to an unused index that must be ignored
  task automatic load_square(input square_t sq);
    for (int r = 0; r < REG_ROWS; r++) begin
      write_reg(r, sq[r]);
    end
    write_reg($urandom_range(REG_ROWS, IDX_TOP), ROW_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_squares++;
  endtask

  function automatic square_t random_square(input int mode);
    square_t sq;
    int      codes[REG_ROWS*REG_COLS];
    int      j, t;
    sq = '0;
    case (mode)
      0: begin
        for (int i = 0; i < REG_ROWS * REG_COLS; i++) codes[i] = i;
        for (int i = REG_ROWS * REG_COLS - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = codes[i];
          codes[i] = codes[j];
          codes[j] = t;
        end
        for (int i = 0; i < REG_ROWS * REG_COLS; i++) begin
          sq[i / REG_COLS][i % REG_COLS] = CODE_W'(codes[i]);
        end
        // a few codes from the unused range push some letters out
        repeat ($urandom_range(0, 2)) begin
          sq[$urandom_range(0, REG_ROWS-1)][$urandom_range(0, REG_COLS-1)] =
            CODE_W'($urandom_range(25, 31));
        end
      end
      1: begin
        for (int r = 0; r < REG_ROWS; r++) sq[r] = ROW_W'($urandom);
      end
      default: begin
        for (int r = 0; r < REG_ROWS; r++) begin
          case ($urandom_range(0, 2))
            0:       sq[r] = '0;
            1:       sq[r] = '1;
            default: sq[r] = ROW_W'($urandom);
          endcase
        end
      end
    endcase
    return sq;
  endfunction

  // mostly letters taken from the square, biased toward shared rows/columns
  task automatic queue_random_pair(input square_t sq);
    int r1, c1, a, b;
    r1 = $urandom_range(0, REG_ROWS-1);
    c1 = $urandom_range(0, REG_COLS-1);
    a  = int'(sq[r1][c1]);
    case ($urandom_range(0, 5))
      0:       b = $urandom_range(0, 31);
      1: begin
        a = $urandom_range(0, 31);
        b = int'(sq[$urandom_range(0, REG_ROWS-1)][$urandom_range(0, REG_COLS-1)]);
      end
      2:       b = int'(sq[r1][$urandom_range(0, REG_COLS-1)]);
      3:       b = int'(sq[$urandom_range(0, REG_ROWS-1)][c1]);
      default: b = int'(sq[$urandom_range(0, REG_ROWS-1)][$urandom_range(0, REG_COLS-1)]);
    endcase
    queue_pair(op_e'($urandom_range(0, 1)), a, b);
  endtask

  initial begin
    square_t sq;
    int      modes[RAND_PHASES];
    modes = '{0, 1, 0, 2, 0};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // square straight out of reset: every cell holds code 0
    queue_pair(OP_ENC, 0, 0);
    queue_pair(OP_DEC, 0, 31);
    queue_pair(OP_ENC, 31, 0);
    wait_drained();

    // plain square, code = 5*row + col
    for (int r = 0; r < REG_ROWS; r++) begin
      for (int c = 0; c < REG_COLS; c++) sq[r][c] = CODE_W'(5 * r + c);
    end
    load_square(sq);
    write_reg(IDX_TOP, '1);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    queue_pair(OP_ENC, 0, 4);     // same row, wraps right
    queue_pair(OP_DEC, 0, 4);     // same row, wraps left
    queue_pair(OP_ENC, 0, 20);    // same column, wraps down
    queue_pair(OP_DEC, 0, 20);    // same column, wraps up
    queue_pair(OP_ENC, 6, 18);    // rectangle
    queue_pair(OP_DEC, 18, 6);
    queue_pair(OP_ENC, 24, 0);
    queue_pair(OP_DEC, 25, 3);    // letter missing
    queue_pair(OP_ENC, 3, 31);
    queue_pair(OP_ENC, 31, 31);   // missing beats same cell
    queue_pair(OP_ENC, 12, 12);   // same cell
    queue_pair(OP_DEC, 12, 12);
    wait_drained();

    // extreme rows, repeated codes and codes 25..29 and 31 in the square
    sq[0] = '1;
    for (int c = 0; c < REG_COLS; c++) sq[1][c] = CODE_W'(25 + c);
    for (int c = 0; c < REG_COLS; c++) sq[2][c] = CODE_W'(10 + c);
    for (int c = 0; c < REG_COLS; c++) sq[3][c] = CODE_W'(15 + c);
    sq[4] = '0;
    load_square(sq);
    queue_pair(OP_ENC, 31, 31);
    queue_pair(OP_ENC, 31, 25);
    queue_pair(OP_DEC, 26, 0);
    queue_pair(OP_DEC, 29, 31);
    queue_pair(OP_ENC, 10, 14);
    queue_pair(OP_DEC, 0, 15);
    queue_pair(OP_ENC, 30, 11);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      sq = random_square(modes[ph]);
      load_square(sq);
      idle_en = (ph != RAND_PHASES - 1);
      repeat (PHASE_PAIRS) queue_random_pair(sq);
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    $display("checked %0d pairs under %0d key squares", n_taken, n_squares);
    $display("outcomes: %0d transformed, %0d missing letter, %0d same cell",
             n_ok, n_miss, n_same);
    if (n_errors == 0 && cipher_out_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
sv/pf_pkg.sv
sv/pf_lane.sv
sv/pf_merge.sv
sv/playfair_digraph_cipher.sv
bench/tb_playfair_digraph_cipher.sv
